[hw/rtl/tdq_pkg.sv]
`default_nettype none
package tdq_pkg;
  localparam int unsigned CapacityDef = 16;
  localparam int unsigned IdBitsDef = 16;
  localparam int unsigned TimeBitsDef = 32;

  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdCancel = 2'd1,
    CmdTick   = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindAdded   = 2'd0,
    KindFull    = 2'd1,
    KindCancel  = 2'd2,
    KindExpired = 2'd3
  } kind_e;
endpackage
`default_nettype wire

[hw/rtl/tdq_mem.sv]
`default_nettype none
module tdq_mem #(
  parameter int unsigned AW = 4,
  parameter int unsigned DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];

  // synchronous write, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

[hw/rtl/timer_deadline_queue.sv]
// channel  | direction | handshake       | payload
// command  | in        | start and !busy | cmd_i now_time_i delay_i target_id_i wants_*_i
// result   | out       | result_valid_o  | kind_o timer_id_o found_o notify_o last_o
// Each slot read passes through StRead and StCheck, as the slot memory's read is registered:
// add reads from the tail down to the insert point moving entries up, then writes;
// cancel searches, then shifts the entries above the match down (StDnRd, StShDn);
// tick removes each expired head and shifts the rest down, then reads the new head,
// until the head is not due or the table is empty.
// A full add or a cancel on an empty table answers without raising busy.
// Results leave through a one-deep buffer and are registered again at the outputs,
// and may follow the next transfer; the receiver cannot stall.
// Reset clears the count and the id counter; slot contents need no clearing.
`default_nettype none
module timer_deadline_queue #(
  parameter int unsigned CAPACITY  = tdq_pkg::CapacityDef,
  parameter int unsigned ID_BITS   = tdq_pkg::IdBitsDef,
  parameter int unsigned TIME_BITS = tdq_pkg::TimeBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] now_time_i,
  input  wire logic [31:0] delay_i,
  input  wire logic [15:0] target_id_i,
  input  wire logic        wants_expiry_notice_i,
  input  wire logic        wants_cancel_notice_i,
  output logic             result_valid_o,
  output logic [1:0]       kind_o,
  output logic [15:0]      timer_id_o,
  output logic             found_o,
  output logic             notify_o,
  output logic             last_o
);
  import tdq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = TIME_BITS + ID_BITS + 2;
  localparam int unsigned TW = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int unsigned CMPW = (ID_BITS > 16) ? ID_BITS : 16;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRead  = 7'b0000010,
    StCheck = 7'b0000100,
    StShUp  = 7'b0001000,
    StShDn  = 7'b0010000,
    StDnRd  = 7'b0100000,
    StPut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [ID_BITS-1:0] idc_q, idc_d;
  cmd_e cmd_q, cmd_d;
  logic [TIME_BITS-1:0] now_q, now_d, dl_q, dl_d;
  logic [15:0] tgt_q, tgt_d;
  logic [1:0] flg_q, flg_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic [TIME_BITS-1:0] r_dl;
  logic [ID_BITS-1:0] r_id;
  logic [1:0] r_flg;
  logic [TIME_BITS:0] sum;
  logic [CMPW-1:0] tgt_cmp;

  logic rv_d;
  logic [1:0] rk_d;
  logic [15:0] rid_d;
  logic rf_d, rn_d, rl_d;

  tdq_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign {r_dl, r_id, r_flg} = rdata;
  assign busy = (state_q != StIdle);
  assign sum = {1'b0, TIME_BITS'(now_time_i[TW-1:0])} + {1'b0, TIME_BITS'(delay_i[TW-1:0])};
  assign tgt_cmp = CMPW'(r_id);

  // command sequencer over the slot memory
  always_comb begin
    state_d = state_q; count_d = count_q; idx_d = idx_q; idc_d = idc_q;
    cmd_d = cmd_q; now_d = now_q; dl_d = dl_q; tgt_d = tgt_q; flg_d = flg_q;
    we = 1'b0; waddr = idx_q[AW-1:0]; wdata = rdata; raddr = idx_q[AW-1:0];
    rv_d = 1'b0; rk_d = KindAdded; rid_d = '0; rf_d = 1'b0; rn_d = 1'b0; rl_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_d = cmd_e'(cmd_i);
          now_d = TIME_BITS'(now_time_i[TW-1:0]);
          dl_d = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
          tgt_d = target_id_i;
          flg_d = {wants_cancel_notice_i, wants_expiry_notice_i};
          case (cmd_e'(cmd_i))
            CmdAdd: begin
              if (count_q == CW'(CAPACITY)) begin
                rv_d = 1'b1; rk_d = KindFull; rl_d = 1'b1;
              end else if (count_q == '0) begin
                state_d = StPut; idx_d = '0;
              end else begin
                state_d = StRead; idx_d = count_q - 1'b1;
              end
            end
            CmdCancel: begin
              if (count_q == '0) begin
                rv_d = 1'b1; rk_d = KindCancel; rid_d = target_id_i; rl_d = 1'b1;
              end else begin
                state_d = StRead; idx_d = '0;
              end
            end
            CmdTick: begin
              if (count_q != '0) begin
                state_d = StRead; idx_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      StRead: state_d = StCheck;
      StCheck: begin
        case (cmd_q)
          CmdAdd: begin
            if (r_dl > dl_q) begin
              // move entry up one slot
              we = 1'b1; waddr = AW'(idx_q + 1'b1);
              if (idx_q == '0) begin
                state_d = StPut;
              end else begin
                idx_d = idx_q - 1'b1; state_d = StRead;
              end
            end else begin
              idx_d = idx_q + 1'b1; state_d = StPut;
            end
          end
          CmdCancel: begin
            if (tgt_cmp == CMPW'(tgt_q)) begin
              rv_d = 1'b1; rk_d = KindCancel; rid_d = tgt_q; rf_d = 1'b1;
              rn_d = r_flg[1]; rl_d = 1'b1;
              count_d = count_q - 1'b1;
              if (idx_q + 1'b1 >= count_q) state_d = StIdle;
              else begin
                state_d = StDnRd; idx_d = idx_q + 1'b1;
              end
            end else if (idx_q + 1'b1 >= count_q) begin
              rv_d = 1'b1; rk_d = KindCancel; rid_d = tgt_q; rl_d = 1'b1;
              state_d = StIdle;
            end else begin
              idx_d = idx_q + 1'b1; state_d = StRead;
            end
          end
          default: begin
            // tick: slot 0 always holds the head
            if (r_dl <= now_q) begin
              rv_d = 1'b1; rk_d = KindExpired; rid_d = 16'(r_id); rn_d = r_flg[0];
              count_d = count_q - 1'b1;
              if (count_q == CW'(1)) begin
                rl_d = 1'b1; state_d = StIdle;
              end else begin
                idx_d = CW'(1); state_d = StDnRd;
              end
            end else begin
              state_d = StIdle;
            end
          end
        endcase
      end
      StDnRd: state_d = StShDn;
      StShDn: begin
        // move entry down one slot
        we = 1'b1; waddr = AW'(idx_q - 1'b1);
        if (idx_q >= count_q) begin
          if (cmd_q == CmdTick) begin
            idx_d = '0; state_d = StRead;
          end else begin
            state_d = StIdle;
          end
        end else begin
          idx_d = idx_q + 1'b1; state_d = StDnRd;
        end
      end
      StPut: begin
        we = 1'b1; waddr = idx_q[AW-1:0];
        wdata = {dl_q, idc_q + 1'b1, flg_q};
        idc_d = idc_q + 1'b1;
        count_d = count_q + 1'b1;
        rv_d = 1'b1; rk_d = KindAdded; rid_d = 16'(idc_q + 1'b1); rl_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // tick: last flag needs lookahead, so the tail result is flagged when it is
  // known that the next head is not due; buffer one result
  logic pend_q, pend_d;
  logic [1:0] pk_q;
  logic [15:0] pid_q;
  logic pf_q, pn_q, pl_q;
  logic flush;

  assign flush = pend_q && (rv_d || state_d == StIdle);
  assign pend_d = rv_d || (pend_q && !flush);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; count_q <= '0; idx_q <= '0; idc_q <= '0;
      cmd_q <= CmdNone; pend_q <= 1'b0; result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; idx_q <= idx_d; idc_q <= idc_d;
      cmd_q <= cmd_d; pend_q <= pend_d;
      result_valid_o <= flush;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d; dl_q <= dl_d; tgt_q <= tgt_d; flg_q <= flg_d;
    if (flush) begin
      kind_o <= pk_q; timer_id_o <= pid_q; found_o <= pf_q; notify_o <= pn_q;
      last_o <= pl_q || (state_d == StIdle && !rv_d);
    end
    if (rv_d) begin
      pk_q <= rk_d; pid_q <= rid_d; pf_q <= rf_d; pn_q <= rn_d; pl_q <= rl_d;
    end
  end

  // the table never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(CAPACITY))
    else $error("count overflow");
  // a result strobe always carries a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(pend_q))
    else $error("result without held entry");
  // a completed add advances the id counter by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPut) |=> idc_q == $past(idc_q) + 1'b1)
    else $error("id counter slip");
endmodule
`default_nettype wire
